@@ src/text_console_writer_core_assert.svh @@
// Assertion macros for the console writer checker.
`ifndef TEXT_CONSOLE_WRITER_CORE_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_CORE_ASSERT_SVH

// Generic clocked assertion with an active-low reset disable.
`define TCW_ASSERT_CR(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("tcw assertion failed");

// Shorthand on the block clock and reset.
`define TCW_ASSERT(label, prop) `TCW_ASSERT_CR(label, clk_i, rst_ni, prop)

`endif

@@ src/tcw_pkg.sv @@
// Shared types and constants for the text console writer.
package tcw_pkg;

  localparam logic [7:0]  CODE_NUL       = 8'h00;
  localparam logic [7:0]  CODE_NEWLINE   = 8'h0A;
  localparam logic [7:0]  CODE_BACKSPACE = 8'h08;
  localparam logic [7:0]  CODE_SPACE     = 8'h20;
  localparam logic [7:0]  RESET_ATTR     = 8'h0F;
  localparam logic [15:0] RESET_CELL     = {RESET_ATTR, CODE_SPACE};

  localparam logic KIND_PUT  = 1'b0;
  localparam logic KIND_READ = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_SCROLL,
    ST_WAIT
  } tcw_state_e;

endpackage

@@ src/tcw_screen_ram.sv @@
// Screen cell memory: one write port, one registered read port.
module tcw_screen_ram import tcw_pkg::*; #(
  parameter int DEPTH = 2000,
  parameter int AW    = 11
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [15:0]   wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [15:0]   rdata_o
);

  logic [15:0] mem [DEPTH];
  logic [15:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/tcw_ctrl.sv @@
// Sequencer: cursor, scroll offset, clearing pass and memory accesses.
module tcw_ctrl import tcw_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25,
  parameter int CELLS   = COLUMNS * ROWS,
  parameter int AW      = $clog2(CELLS),
  parameter int CW      = $clog2(COLUMNS),
  parameter int RW      = $clog2(ROWS)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  // input word
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic          kind_i,
  input  logic [7:0]    char_code_i,
  input  logic [AW-1:0] cell_index_i,
  input  logic [7:0]    attr_i,
  // result hand-off
  input  logic          out_free_i,
  output logic          res_load_o,
  output logic [15:0]   res_value_o,
  output logic [CW-1:0] res_col_o,
  output logic [RW-1:0] res_row_o,
  // memory
  output logic          mem_we_o,
  output logic [AW-1:0] mem_waddr_o,
  output logic [15:0]   mem_wdata_o,
  output logic          mem_re_o,
  output logic [AW-1:0] mem_raddr_o,
  input  logic [15:0]   mem_rdata_i
);

  localparam logic [AW:0]   CellsW   = (AW + 1)'(CELLS);
  localparam logic [AW-1:0] ColsA    = AW'(COLUMNS);
  localparam logic [AW-1:0] LastCell = AW'(CELLS - 1);
  localparam logic [AW-1:0] LastCntA = AW'(COLUMNS - 1);
  localparam logic [CW-1:0] LastCol  = CW'(COLUMNS - 1);
  localparam logic [RW-1:0] LastRow  = RW'(ROWS - 1);

  function automatic logic [AW-1:0] wrap_addr(input logic [AW:0] sum);
    logic [AW:0] res;
    res = (sum >= CellsW) ? (sum - CellsW) : sum;
    return res[AW-1:0];
  endfunction

  tcw_state_e    state_q, state_d;
  logic [AW-1:0] cnt_q, cnt_d;
  logic [AW-1:0] base_q, base_d;
  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic          kind_q;
  logic [7:0]    char_q;
  logic          oor_q;

  logic          accept;
  logic          is_nul, is_nl, is_bs;
  logic [CW-1:0] wr_col, nxt_col;
  logic [RW-1:0] wr_row, nxt_row;
  logic          do_write, do_scroll;
  logic [AW-1:0] wr_lin, wr_phys, rd_phys;
  logic          cell_oor;
  logic          sweep_last;

  assign accept = (state_q == ST_IDLE) && in_valid_i;
  assign is_nul = (char_q == CODE_NUL);
  assign is_nl  = (char_q == CODE_NEWLINE);
  assign is_bs  = (char_q == CODE_BACKSPACE);

  // cell hit by a put, and the cursor afterwards
  always_comb begin
    wr_col    = col_q;
    wr_row    = row_q;
    nxt_col   = col_q;
    nxt_row   = row_q;
    do_scroll = 1'b0;
    if (kind_q == KIND_PUT) begin
      priority if (is_nul) begin
        nxt_col = col_q;
      end else if (is_bs) begin
        priority if (col_q != '0) begin
          wr_col = col_q - CW'(1);
        end else if (row_q != '0) begin
          wr_col = LastCol;
          wr_row = row_q - RW'(1);
        end
        nxt_col = wr_col;
        nxt_row = wr_row;
      end else if (is_nl || (col_q == LastCol)) begin
        nxt_col = '0;
        if (row_q == LastRow) begin
          do_scroll = 1'b1;
        end else begin
          nxt_row = row_q + RW'(1);
        end
      end else begin
        nxt_col = col_q + CW'(1);
      end
    end
  end

  assign do_write = (kind_q == KIND_PUT) && !is_nul && !is_nl;
  assign wr_lin   = (AW'(wr_row) * ColsA) + AW'(wr_col);
  assign wr_phys  = wrap_addr({1'b0, wr_lin} + {1'b0, base_q});

  assign cell_oor = ({1'b0, cell_index_i} >= CellsW);
  assign rd_phys  = cell_oor ? '0 : wrap_addr({1'b0, cell_index_i} + {1'b0, base_q});

  assign sweep_last = (cnt_q == LastCntA);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (cnt_q == LastCell) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        priority if (do_scroll) state_d = ST_SCROLL;
        else if (out_free_i)    state_d = ST_IDLE;
        else                    state_d = ST_WAIT;
      end
      ST_SCROLL: begin
        if (sweep_last) state_d = out_free_i ? ST_IDLE : ST_WAIT;
      end
      ST_WAIT: begin
        if (out_free_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_stall_o  = 1'b1;
    mem_we_o    = 1'b0;
    mem_waddr_o = wr_phys;
    mem_wdata_o = {attr_i, is_bs ? CODE_SPACE : char_q};
    mem_re_o    = 1'b0;
    mem_raddr_o = rd_phys;
    res_load_o  = 1'b0;
    res_col_o   = col_q;
    res_row_o   = row_q;
    unique case (state_q)
      ST_CLEAR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = cnt_q;
        mem_wdata_o = RESET_CELL;
      end
      ST_IDLE: begin
        in_stall_o = 1'b0;
        mem_re_o   = in_valid_i;
      end
      ST_EXEC: begin
        mem_we_o   = do_write;
        res_load_o = !do_scroll && out_free_i;
        res_col_o  = nxt_col;
        res_row_o  = nxt_row;
      end
      ST_SCROLL: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = base_q + cnt_q;
        mem_wdata_o = {attr_i, CODE_SPACE};
        res_load_o  = sweep_last && out_free_i;
      end
      ST_WAIT: begin
        res_load_o = out_free_i;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  assign res_value_o = ((kind_q == KIND_READ) && !oor_q) ? mem_rdata_i : '0;

  // counter, cursor and scroll offset
  always_comb begin
    cnt_d  = cnt_q;
    col_d  = col_q;
    row_d  = row_q;
    base_d = base_q;
    unique case (state_q)
      ST_CLEAR:  cnt_d = cnt_q + AW'(1);
      ST_EXEC: begin
        cnt_d = '0;
        col_d = nxt_col;
        row_d = nxt_row;
      end
      ST_SCROLL: begin
        cnt_d = cnt_q + AW'(1);
        // old top row is now the blank bottom row
        if (sweep_last) base_d = wrap_addr({1'b0, base_q} + {1'b0, ColsA});
      end
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      cnt_q   <= '0;
      col_q   <= '0;
      row_q   <= '0;
      base_q  <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      col_q   <= col_d;
      row_q   <= row_d;
      base_q  <= base_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= kind_i;
      char_q <= char_code_i;
      oor_q  <= cell_oor;
    end
  end

endmodule

@@ src/text_console_writer_core.sv @@
// Top level of the text console writer: config register, output word register, wiring.
//
// Text console writer. Holds a COLUMNS x ROWS screen of 16-bit cells (attribute in
// the high byte, character in the low byte) and a cursor. A put word (kind 0)
// writes a character at the cursor and advances it; newline goes to column 0 of
// the next row, backspace steps back and blanks the cell, byte 0 only reports the
// cursor. Moving past the last row scrolls the screen up one row. A read word
// (kind 1) returns the cell at cell_index (zero beyond the screen). Every input
// word yields one output word with the cursor after the word.
// Timing: one word is in flight at a time. For a put or read, the accept cycle
// issues the memory read, and the result register loads in the execute state that
// follows, or from the wait state once the output register is free; a put that
// scrolls first passes through the scroll state, writing blanks into the new bottom
// row through the single memory write port. Scrolling itself costs no copy: rows
// are kept in a rotated order and a base offset moves by one row. After reset a
// clearing pass writes the reset blank into all COLUMNS*ROWS cells, during which
// in_stall_o stays high; config writes are taken throughout. The result sits in an
// output register, so the next word is accepted while the previous result still
// waits on out_stall_i. cfg_we_i/cfg_wdata_i set the attribute used for written
// characters and blanks; write it only while the block is idle.
module text_console_writer_core import tcw_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // config
  input  logic                               cfg_we_i,
  input  logic [7:0]                         cfg_wdata_i,
  // input words
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               kind_i,
  input  logic [7:0]                         char_code_i,
  input  logic [$clog2(COLUMNS*ROWS)-1:0]    cell_index_i,
  // output words
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [15:0]                        cell_value_o,
  output logic [$clog2(COLUMNS)-1:0]         cursor_column_o,
  output logic [$clog2(ROWS)-1:0]            cursor_row_o
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS);

  logic [7:0]    attr_q;
  logic          out_valid_q, out_valid_d;
  logic [15:0]   cell_value_q;
  logic [CW-1:0] col_out_q;
  logic [RW-1:0] row_out_q;

  logic          out_free;
  logic          res_load;
  logic [15:0]   res_value;
  logic [CW-1:0] res_col;
  logic [RW-1:0] res_row;

  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [15:0]   mem_wdata, mem_rdata;

  // attribute register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q <= RESET_ATTR;
    end else if (cfg_we_i) begin
      attr_q <= cfg_wdata_i;
    end
  end

  tcw_ctrl #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .kind_i       (kind_i),
    .char_code_i  (char_code_i),
    .cell_index_i (cell_index_i),
    .attr_i       (attr_q),
    .out_free_i   (out_free),
    .res_load_o   (res_load),
    .res_value_o  (res_value),
    .res_col_o    (res_col),
    .res_row_o    (res_row),
    .mem_we_o     (mem_we),
    .mem_waddr_o  (mem_waddr),
    .mem_wdata_o  (mem_wdata),
    .mem_re_o     (mem_re),
    .mem_raddr_o  (mem_raddr),
    .mem_rdata_i  (mem_rdata)
  );

  tcw_screen_ram #(
    .DEPTH (CELLS),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // output word register; free when empty or being taken this cycle
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      cell_value_q <= res_value;
      col_out_q    <= res_col;
      row_out_q    <= res_row;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign cell_value_o    = cell_value_q;
  assign cursor_column_o = col_out_q;
  assign cursor_row_o    = row_out_q;

endmodule

@@ src/tcw_checker.sv @@
// Port-level checker for the text console writer, bound to the top level.
`include "text_console_writer_core_assert.svh"

module tcw_checker #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_stall_o,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input logic [15:0]                     cell_value_o,
  input logic [$clog2(COLUMNS)-1:0]      cursor_column_o,
  input logic [$clog2(ROWS)-1:0]         cursor_row_o
);

  // a stalled result word holds
  `TCW_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(cell_value_o))

  // one word in flight: stall right after an accept
  `TCW_ASSERT(a_one_in_flight, in_valid_i && !in_stall_o |=> in_stall_o)

  // reported cursor always lies on the screen
  `TCW_ASSERT(a_col_range, out_valid_o |-> cursor_column_o < COLUMNS)
  `TCW_ASSERT(a_row_range, out_valid_o |-> cursor_row_o < ROWS)

endmodule

bind text_console_writer_core tcw_checker #(
  .COLUMNS (COLUMNS),
  .ROWS    (ROWS)
) u_tcw_checker (.*);
